[hdl/wavhp_pkg.sv]
`timescale 1ns / 1ps

package wavhp_pkg;

    // Depth of the queue between the byte intake and the parser.
    localparam int QUEUE_DEPTH = 4;

    // Packed result word width: all result fields except kind.
    localparam int RESULT_W = 136;

    // Four-character tags as little-endian words.
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    // Byte positions inside the fixed header where a field completes.
    localparam logic [31:0] POS_RIFF_END   = 32'd3;
    localparam logic [31:0] POS_WAVE_END   = 32'd11;
    localparam logic [31:0] POS_FMT_END    = 32'd15;
    localparam logic [31:0] POS_CHAN_END   = 32'd23;
    localparam logic [31:0] POS_RATE_END   = 32'd27;
    localparam logic [31:0] POS_BRATE_END  = 32'd31;
    localparam logic [31:0] POS_FIXED_LAST = 32'd35;

    // Length of a chunk header in bytes.
    localparam logic [31:0] CHUNK_HDR_LEN = 32'd8;

    // Kind of a queued item, decided by the intake.
    typedef enum logic {
        ITEM_BYTE = 1'b0,
        ITEM_END  = 1'b1
    } item_kind_t;

    typedef struct packed {
        item_kind_t  kind;
        logic [7:0]  value;
    } queue_item_t;

    // Kind of a result.
    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_ERROR  = 2'd1,
        KIND_DATA   = 2'd2
    } result_kind_t;

    // Error codes of a header error result.
    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_RIFF_TAG    = 3'd1,
        ERR_WAVE_TAG    = 3'd2,
        ERR_FMT_TAG     = 3'd3,
        ERR_BYTE_RATE   = 3'd4,
        ERR_BLOCK_ALIGN = 3'd5,
        ERR_TRUNCATED   = 3'd6
    } err_code_t;

    // Parser states.
    typedef enum logic [2:0] {
        ST_FIXED = 3'd0,
        ST_MUL1  = 3'd1,
        ST_MUL2  = 3'd2,
        ST_CHECK = 3'd3,
        ST_CHDR  = 3'd4,
        ST_SKIP  = 3'd5,
        ST_DATA  = 3'd6,
        ST_HALT  = 3'd7
    } parse_state_t;

endpackage

[hdl/wav_header_parser.sv]
`timescale 1ns / 1ps

// WAV header parser. Takes the file one byte per request (s_tuser high marks
// the end of the stream), checks the fixed RIFF/WAVE/fmt header and the byte
// rate and block align, skips chunks until the data chunk, then sends one
// header result followed by every data byte. Bytes enter a queue of
// QUEUE_DEPTH entries at up to one per cycle and the parser handles one byte
// per cycle while its output register is free; at the end of the fixed
// header the parser passes through two multiply stages and a compare for the
// format check, which the queue absorbs. When the queue is empty and the
// output register is free, a result is presented from the clock edge after
// the one that takes its byte. After an error or an end of stream all input
// is taken and dropped until reset.
module wav_header_parser #(
    parameter int QUEUE_DEPTH = wavhp_pkg::QUEUE_DEPTH
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,  // [7:0] stream_byte
    input  logic                             s_tuser,  // [0] stream_end
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [2:0] error_code, [18:3] channel_count, [50:19] sample_rate_out,
    // [63:51] bytes_per_sample, [95:64] data_size, [127:96] data_offset,
    // [135:128] data_byte
    output logic [wavhp_pkg::RESULT_W-1:0]   m_tdata,
    output logic [1:0]                       m_tuser   // [1:0] kind
);

    logic                   q_valid;
    logic                   q_pop;
    wavhp_pkg::queue_item_t q_item;

    // Intake and queue.
    wavhp_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // Parser, format check and result register.
    wavhp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

[hdl/wavhp_front.sv]
`timescale 1ns / 1ps

module wavhp_front #(
    parameter int QUEUE_DEPTH = wavhp_pkg::QUEUE_DEPTH
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,   // stream_byte
    input  logic                    s_tuser,   // stream_end
    output logic                    q_valid,
    output wavhp_pkg::queue_item_t  q_item,
    input  logic                    q_pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    wavhp_pkg::queue_item_t q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    wavhp_pkg::queue_item_t in_item;

    // A request is taken whenever the queue has room.
    assign s_tready = (count_reg != CNT_FULL);
    assign push     = s_tvalid && s_tready;

    // Classify the request: an end marker carries no byte.
    always_comb begin
        in_item.kind  = s_tuser ? wavhp_pkg::ITEM_END : wavhp_pkg::ITEM_BYTE;
        in_item.value = s_tuser ? 8'd0 : s_tdata;
    end

    assign q_valid = (count_reg != '0);
    assign q_item  = q_mem[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

    // The parser never pops an empty queue.
    assert property (@(posedge aclk) disable iff (!aresetn) q_pop |-> q_valid)
        else $error("queue popped while empty");

    // The fill count stays within the depth.
    assert property (@(posedge aclk) disable iff (!aresetn) count_reg <= CNT_FULL)
        else $error("queue fill count above depth");

endmodule

[hdl/wavhp_back.sv]
`timescale 1ns / 1ps

module wavhp_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 q_valid,
    input  wavhp_pkg::queue_item_t               q_item,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [wavhp_pkg::RESULT_W-1:0]       m_tdata,
    output logic [1:0]                           m_tuser
);

    wavhp_pkg::parse_state_t state_reg, state_next;
    logic [31:0] byte_pos_reg, byte_pos_next;
    logic [31:0] skip_reg, skip_next;
    logic [31:0] tag_reg, tag_next;
    logic [2:0]  flags_reg, flags_next;
    logic [15:0] channels_reg, channels_next;
    logic [31:0] rate_reg, rate_next;
    logic [31:0] byte_rate_reg, byte_rate_next;
    logic [15:0] block_align_reg, block_align_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] chunk_reg, chunk_next;
    logic [31:0] prod1_reg, prod1_next;
    logic [31:0] prod2_reg, prod2_next;
    logic [31:0] align_prod_reg, align_prod_next;
    logic        out_valid_reg, out_valid_next;
    wavhp_pkg::result_kind_t out_kind_reg, out_kind_next;
    logic [wavhp_pkg::RESULT_W-1:0] out_data_reg, out_data_next;

    logic        out_free;
    logic        consuming;
    logic        is_end;
    logic [31:0] tag_shifted;
    logic [31:0] hdr_count;
    logic [31:0] hdr_left;
    logic        rate_ok;
    logic        align_ok;
    wavhp_pkg::err_code_t check_code;

    // Packs the result fields, error code in the lowest bits.
    function automatic logic [wavhp_pkg::RESULT_W-1:0] pack_result(
        input logic [2:0]  code,
        input logic [15:0] chans,
        input logic [31:0] srate,
        input logic [12:0] bps,
        input logic [31:0] dsize,
        input logic [31:0] doffset,
        input logic [7:0]  dbyte
    );
        return {dbyte, doffset, dsize, bps, srate, chans, code};
    endfunction

    // The output register can take a new result this cycle.
    assign out_free  = !out_valid_reg || m_tready;
    assign consuming = (state_reg == wavhp_pkg::ST_FIXED) || (state_reg == wavhp_pkg::ST_CHDR)
                    || (state_reg == wavhp_pkg::ST_SKIP) || (state_reg == wavhp_pkg::ST_DATA)
                    || (state_reg == wavhp_pkg::ST_HALT);
    assign q_pop     = q_valid && out_free && consuming;
    assign is_end    = (q_item.kind == wavhp_pkg::ITEM_END);

    // The last four bytes as a little-endian word, including this one.
    assign tag_shifted = {q_item.value, tag_reg[31:8]};

    // Bytes still to read in the chunk header, before and after this one.
    assign hdr_count = ((skip_reg == 32'd0) || (skip_reg > wavhp_pkg::CHUNK_HDR_LEN))
                     ? wavhp_pkg::CHUNK_HDR_LEN : skip_reg;
    assign hdr_left  = hdr_count - 32'd1;

    // Format checks on the products from the multiply stages.
    assign rate_ok  = (byte_rate_reg == {3'b000, prod2_reg[31:3]});
    assign align_ok = (align_prod_reg[31:19] == 13'd0)
                   && (align_prod_reg[18:3] == block_align_reg);

    always_comb begin
        if (!flags_reg[0]) begin
            check_code = wavhp_pkg::ERR_RIFF_TAG;
        end else if (!flags_reg[1]) begin
            check_code = wavhp_pkg::ERR_WAVE_TAG;
        end else if (!flags_reg[2]) begin
            check_code = wavhp_pkg::ERR_FMT_TAG;
        end else if (!rate_ok) begin
            check_code = wavhp_pkg::ERR_BYTE_RATE;
        end else if (!align_ok) begin
            check_code = wavhp_pkg::ERR_BLOCK_ALIGN;
        end else begin
            check_code = wavhp_pkg::ERR_NONE;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wavhp_pkg::ST_FIXED: begin
                if (q_pop) begin
                    if (is_end) begin
                        state_next = wavhp_pkg::ST_HALT;
                    end else if (byte_pos_reg == wavhp_pkg::POS_FIXED_LAST) begin
                        state_next = wavhp_pkg::ST_MUL1;
                    end
                end
            end
            wavhp_pkg::ST_MUL1: begin
                state_next = wavhp_pkg::ST_MUL2;
            end
            wavhp_pkg::ST_MUL2: begin
                state_next = wavhp_pkg::ST_CHECK;
            end
            wavhp_pkg::ST_CHECK: begin
                if (out_free) begin
                    state_next = (check_code != wavhp_pkg::ERR_NONE)
                               ? wavhp_pkg::ST_HALT : wavhp_pkg::ST_CHDR;
                end
            end
            wavhp_pkg::ST_CHDR: begin
                if (q_pop) begin
                    if (is_end) begin
                        state_next = wavhp_pkg::ST_HALT;
                    end else if (hdr_left == 32'd0) begin
                        if (chunk_reg == wavhp_pkg::TAG_DATA) begin
                            state_next = wavhp_pkg::ST_DATA;
                        end else if (tag_shifted != 32'd0) begin
                            state_next = wavhp_pkg::ST_SKIP;
                        end
                    end
                end
            end
            wavhp_pkg::ST_SKIP: begin
                if (q_pop) begin
                    if (is_end) begin
                        state_next = wavhp_pkg::ST_HALT;
                    end else if (skip_reg == 32'd1) begin
                        state_next = wavhp_pkg::ST_CHDR;
                    end
                end
            end
            wavhp_pkg::ST_DATA: begin
                if (q_pop && is_end) begin
                    state_next = wavhp_pkg::ST_HALT;
                end
            end
            wavhp_pkg::ST_HALT: begin
                state_next = wavhp_pkg::ST_HALT;
            end
            default: begin
                state_next = wavhp_pkg::ST_FIXED;
            end
        endcase
    end

    // Datapath and result register updates.
    always_comb begin
        byte_pos_next    = byte_pos_reg;
        skip_next        = skip_reg;
        tag_next         = tag_reg;
        flags_next       = flags_reg;
        channels_next    = channels_reg;
        rate_next        = rate_reg;
        byte_rate_next   = byte_rate_reg;
        block_align_next = block_align_reg;
        bits_next        = bits_reg;
        chunk_next       = chunk_reg;
        prod1_next       = prod1_reg;
        prod2_next       = prod2_reg;
        align_prod_next  = align_prod_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_kind_next    = out_kind_reg;
        out_data_next    = out_data_reg;

        // Every byte before the data phase advances the position (saturating) and the tag window.
        if (q_pop && !is_end && ((state_reg == wavhp_pkg::ST_FIXED)
                || (state_reg == wavhp_pkg::ST_CHDR) || (state_reg == wavhp_pkg::ST_SKIP))) begin
            if (byte_pos_reg != 32'hFFFF_FFFF) begin
                byte_pos_next = byte_pos_reg + 32'd1;
            end
            tag_next = tag_shifted;
        end

        // An early end before the data chunk is a truncation error.
        if (q_pop && is_end && ((state_reg == wavhp_pkg::ST_FIXED)
                || (state_reg == wavhp_pkg::ST_CHDR) || (state_reg == wavhp_pkg::ST_SKIP))) begin
            out_valid_next = 1'b1;
            out_kind_next  = wavhp_pkg::KIND_ERROR;
            out_data_next  = pack_result(wavhp_pkg::ERR_TRUNCATED, 16'd0, 32'd0, 13'd0,
                                         32'd0, 32'd0, 8'd0);
        end

        case (state_reg)
            wavhp_pkg::ST_FIXED: begin
                if (q_pop && !is_end) begin
                    case (byte_pos_reg)
                        wavhp_pkg::POS_RIFF_END: begin
                            if (tag_shifted == wavhp_pkg::TAG_RIFF) begin
                                flags_next[0] = 1'b1;
                            end
                        end
                        wavhp_pkg::POS_WAVE_END: begin
                            if (tag_shifted == wavhp_pkg::TAG_WAVE) begin
                                flags_next[1] = 1'b1;
                            end
                        end
                        wavhp_pkg::POS_FMT_END: begin
                            if (tag_shifted == wavhp_pkg::TAG_FMT) begin
                                flags_next[2] = 1'b1;
                            end
                        end
                        wavhp_pkg::POS_CHAN_END: begin
                            channels_next = tag_shifted[31:16];
                        end
                        wavhp_pkg::POS_RATE_END: begin
                            rate_next = tag_shifted;
                        end
                        wavhp_pkg::POS_BRATE_END: begin
                            byte_rate_next = tag_shifted;
                        end
                        wavhp_pkg::POS_FIXED_LAST: begin
                            block_align_next = tag_shifted[15:0];
                            bits_next        = tag_shifted[31:16];
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // First multiply stage: rate times channels, channels times bits.
            wavhp_pkg::ST_MUL1: begin
                prod1_next      = 32'(rate_reg * 32'(channels_reg));
                align_prod_next = 32'(channels_reg) * 32'(bits_reg);
            end
            // Second multiply stage: times bits per sample.
            wavhp_pkg::ST_MUL2: begin
                prod2_next = 32'(prod1_reg * 32'(bits_reg));
            end
            wavhp_pkg::ST_CHECK: begin
                if (out_free) begin
                    if (check_code != wavhp_pkg::ERR_NONE) begin
                        out_valid_next = 1'b1;
                        out_kind_next  = wavhp_pkg::KIND_ERROR;
                        out_data_next  = pack_result(check_code, 16'd0, 32'd0, 13'd0,
                                                     32'd0, 32'd0, 8'd0);
                    end else begin
                        skip_next = wavhp_pkg::CHUNK_HDR_LEN;
                    end
                end
            end
            // Chunk header: tag in the first four bytes, size in the last four.
            wavhp_pkg::ST_CHDR: begin
                if (q_pop && !is_end) begin
                    skip_next = hdr_left;
                    if (hdr_left == 32'd4) begin
                        chunk_next = tag_shifted;
                    end
                    if (hdr_left == 32'd0) begin
                        chunk_next = tag_shifted;
                        if (chunk_reg == wavhp_pkg::TAG_DATA) begin
                            out_valid_next = 1'b1;
                            out_kind_next  = wavhp_pkg::KIND_HEADER;
                            out_data_next  = pack_result(wavhp_pkg::ERR_NONE, channels_reg,
                                                         rate_reg, bits_reg[15:3], tag_shifted,
                                                         byte_pos_next, 8'd0);
                        end else if (tag_shifted == 32'd0) begin
                            skip_next = wavhp_pkg::CHUNK_HDR_LEN;
                        end else begin
                            skip_next = tag_shifted;
                        end
                    end
                end
            end
            wavhp_pkg::ST_SKIP: begin
                if (q_pop && !is_end) begin
                    skip_next = (skip_reg == 32'd1) ? wavhp_pkg::CHUNK_HDR_LEN
                                                    : skip_reg - 32'd1;
                end
            end
            wavhp_pkg::ST_DATA: begin
                if (q_pop && !is_end) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = wavhp_pkg::KIND_DATA;
                    out_data_next  = pack_result(wavhp_pkg::ERR_NONE, 16'd0, 32'd0, 13'd0,
                                                 32'd0, 32'd0, q_item.value);
                end
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= wavhp_pkg::ST_FIXED;
            byte_pos_reg  <= 32'd0;
            skip_reg      <= 32'd0;
            tag_reg       <= 32'd0;
            flags_reg     <= 3'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            byte_pos_reg  <= byte_pos_next;
            skip_reg      <= skip_next;
            tag_reg       <= tag_next;
            flags_reg     <= flags_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Format fields, products and the result payload.
    always_ff @(posedge aclk) begin
        channels_reg    <= channels_next;
        rate_reg        <= rate_next;
        byte_rate_reg   <= byte_rate_next;
        block_align_reg <= block_align_next;
        bits_reg        <= bits_next;
        chunk_reg       <= chunk_next;
        prod1_reg       <= prod1_next;
        prod2_reg       <= prod2_next;
        align_prod_reg  <= align_prod_next;
        out_kind_reg    <= out_kind_next;
        out_data_reg    <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    // Once halted, the parser stays halted until reset.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == wavhp_pkg::ST_HALT |=> state_reg == wavhp_pkg::ST_HALT)
        else $error("parser left the halted state");

    // A chunk body being skipped always has bytes left.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == wavhp_pkg::ST_SKIP |-> skip_reg != 32'd0)
        else $error("skip count is zero while skipping");

    // Data results come only from bytes taken in the data phase.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop && state_reg != wavhp_pkg::ST_DATA
        |=> !(out_valid_reg && out_kind_reg == wavhp_pkg::KIND_DATA))
        else $error("data result outside the data phase");

endmodule
